/* rtl/ssd_pkg.sv */
// ssd_pkg: shared types, constants and the segment table of the scan shift driver
// no dependencies; imported by every module of the block
`default_nettype none

package ssd_pkg;

   // display geometry
   localparam int DIGIT_COUNT  = 8;
   localparam int DIGIT_W      = 4;
   localparam int INDEX_W      = 3;
   localparam int SAMPLE_W     = 8;
   localparam int BYTE_W       = 8;

   // queue between front and back
   localparam int QUEUE_DEPTH  = 2;

   // events per scan step
   localparam int STEP_EVENTS  = 34;
   localparam int EVENT_W      = 6;

   // event positions within a step
   localparam logic [EVENT_W-1:0] EV_BLANK_LATCH = EVENT_W'(16);
   localparam logic [EVENT_W-1:0] EV_FINAL_LATCH = EVENT_W'(STEP_EVENTS - 1);

   // reset value of the wrap register
   localparam logic [INDEX_W-1:0] WRAP_RESET = INDEX_W'(5);

   // segment code of a blank digit
   localparam logic [BYTE_W-1:0] BLANK_CODE = 8'hff;

   // one scan step waiting for the back end
   typedef struct packed {
      logic [BYTE_W-1:0] select;
      logic [BYTE_W-1:0] segments;
   } ssd_entry_type;

   // active-low segment code of one decimal digit
   function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
      logic [BYTE_W-1:0] code;
      unique case (digit)
         4'd0:    code = 8'hc0;
         4'd1:    code = 8'hf9;
         4'd2:    code = 8'ha4;
         4'd3:    code = 8'hb0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hf8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = BLANK_CODE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

/* rtl/seven_segment_scan_shift_driver.sv */
// seven_segment_scan_shift_driver: top level of the multiplexed display scan driver
// depends on ssd_pkg, ssd_front, ssd_queue, ssd_back
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  sample_value
//   rsp_      out        rsp_tvalid/rsp_tready  serial_bit, is_latch (tuser), last (tlast)
//   csr_      in         csr_valid/csr_ready    wrap_digit
//
// each sample produces 34 bus events, one per cycle unless rsp_tready stalls, set by the back end event sequencer
// the first event leaves in the cycle after the step is taken from the queue
// samples are taken while the entry queue has room, so accepts run ahead of the bus
// a stalled rsp_tready holds the output register and the sequencer; the queue fills
// synchronous reset: scan index 0, all digits 0, wrap_digit 5, queue empty
`default_nettype none

module seven_segment_scan_shift_driver
   import ssd_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   // sample input
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] sample_value
   // bus events
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata,   // [0] serial_bit, [7:1] zero
   output logic               rsp_tuser,   // [0] is_latch
   output logic               rsp_tlast,   // last_of_step
   // wrap register
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_data     // wrap_digit
);

   ssd_entry_type entry, head;
   logic          full, empty, pop, accept, out_bit;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {7'b0, out_bit};

   // front: classify sample, update scan state
   ssd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .sample    (req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .entry     (entry)
   );

   // queue of pending scan steps
   ssd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   // back: serial event sequencer
   ssd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_bit   (out_bit),
      .out_latch (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/ssd_front.sv */
// ssd_front: accepts samples, builds the scan step entry, keeps scan index and digits
// depends on ssd_pkg
`default_nettype none

module ssd_front
   import ssd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // sample input
   input  wire logic                accept,
   input  wire logic [SAMPLE_W-1:0] sample,
   // wrap register write
   input  wire logic                csr_write,
   input  wire logic [INDEX_W-1:0]  csr_value,
   // entry toward the queue
   output ssd_entry_type            entry
);

   logic [INDEX_W-1:0] scan_index_ff, scan_index_in;
   logic [INDEX_W-1:0] wrap_digit_ff;
   logic [DIGIT_W-1:0] digit_ff [DIGIT_COUNT];
   logic [INDEX_W:0]   index_inc;
   logic [1:0]         hundreds;
   logic [6:0]         rest;
   logic [14:0]        tens_prod;
   logic [DIGIT_W-1:0] tens;
   logic [DIGIT_W-1:0] ones;

   // entry for the current scan position
   always_comb begin
      entry.select   = BYTE_W'(1) << scan_index_ff;
      entry.segments = seg_code(digit_ff[scan_index_ff]);
   end

   // index advance with reload
   always_comb begin
      index_inc = {1'b0, scan_index_ff} + (INDEX_W+1)'(1);
      if (index_inc >= (INDEX_W+1)'(DIGIT_COUNT)) begin
         scan_index_in = wrap_digit_ff;
      end else begin
         scan_index_in = index_inc[INDEX_W-1:0];
      end
   end

   // decimal split of the sample
   always_comb begin
      if (sample >= SAMPLE_W'(200)) begin
         hundreds = 2'd2;
         rest     = 7'(sample - SAMPLE_W'(200));
      end else if (sample >= SAMPLE_W'(100)) begin
         hundreds = 2'd1;
         rest     = 7'(sample - SAMPLE_W'(100));
      end else begin
         hundreds = 2'd0;
         rest     = sample[6:0];
      end
      // divide by ten through reciprocal 205/2048, exact below 100
      tens_prod = 15'(rest) * 15'd205;
      tens      = tens_prod[14:11];
      ones      = 4'(rest - ({3'b0, tens} << 3) - ({3'b0, tens} << 1));
   end

   // scan index and wrap register
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_index_ff <= '0;
         wrap_digit_ff <= WRAP_RESET;
      end else begin
         if (accept) begin
            scan_index_ff <= scan_index_in;
         end
         if (csr_write) begin
            wrap_digit_ff <= csr_value;
         end
      end
   end

   // digit store, upper three positions take the new reading
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_ff[i] <= '0;
         end
      end else if (accept) begin
         digit_ff[5] <= DIGIT_W'(hundreds);
         digit_ff[6] <= tens;
         digit_ff[7] <= ones;
      end
   end

endmodule

`default_nettype wire

/* rtl/ssd_queue.sv */
// ssd_queue: short queue of scan step entries between front and back
// depends on ssd_pkg
`default_nettype none

module ssd_queue
   import ssd_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  ssd_entry_type push_entry,
   output logic          full,
   input  wire logic     pop,
   output ssd_entry_type head,
   output logic          empty
);

   localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   ssd_entry_type        slot_ff [Depth];
   logic [AddrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CountW-1:0]    count_ff;

   assign full  = (count_ff == CountW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AddrW'(Depth - 1)) ? '0 : wr_ptr_ff + AddrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AddrW'(Depth - 1)) ? '0 : rd_ptr_ff + AddrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CountW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CountW'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/ssd_back.sv */
// ssd_back: plays one scan step as 34 serial bus events into an output register
// depends on ssd_pkg
`default_nettype none

module ssd_back
   import ssd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   // queue side
   input  ssd_entry_type head,
   input  wire logic     empty,
   output logic          pop,
   // event output
   output logic          out_valid,
   input  wire logic     out_ready,
   output logic          out_bit,
   output logic          out_latch,
   output logic          out_last
);

   logic                 busy_ff;
   logic [EVENT_W-1:0]   event_ff;
   logic [2*BYTE_W-1:0]  shift_ff;
   logic                 valid_ff, bit_ff, latch_ff, last_ff;
   logic                 advance;

   assign advance   = !valid_ff || out_ready;
   assign pop       = advance && !busy_ff && !empty;
   assign out_valid = valid_ff;
   assign out_bit   = bit_ff;
   assign out_latch = latch_ff;
   assign out_last  = last_ff;

   // step sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         event_ff <= '0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         if (pop) begin
            // first blanking bit goes out on the load cycle
            busy_ff  <= 1'b1;
            event_ff <= EVENT_W'(1);
            valid_ff <= 1'b1;
         end else if (busy_ff) begin
            busy_ff  <= (event_ff != EV_FINAL_LATCH);
            event_ff <= event_ff + EVENT_W'(1);
            valid_ff <= 1'b1;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   // event payload
   always_ff @(posedge clock) begin
      if (advance) begin
         if (pop) begin
            shift_ff <= {head.select, head.segments};
            bit_ff   <= 1'b1;
            latch_ff <= 1'b0;
            last_ff  <= 1'b0;
         end else if (busy_ff) begin
            priority if (event_ff < EV_BLANK_LATCH) begin
               bit_ff   <= 1'b1;
               latch_ff <= 1'b0;
               last_ff  <= 1'b0;
            end else if (event_ff == EV_BLANK_LATCH || event_ff == EV_FINAL_LATCH) begin
               bit_ff   <= 1'b0;
               latch_ff <= 1'b1;
               last_ff  <= (event_ff == EV_FINAL_LATCH);
            end else begin
               // select byte then segment byte, msb first
               bit_ff   <= shift_ff[2*BYTE_W-1];
               latch_ff <= 1'b0;
               last_ff  <= 1'b0;
               shift_ff <= {shift_ff[2*BYTE_W-2:0], 1'b0};
            end
         end
      end
   end

endmodule

`default_nettype wire

/* verif/seven_segment_scan_shift_driver_tb.sv */
// seven_segment_scan_shift_driver_tb: self-checking bench for the display scan shift driver
// depends on ssd_pkg and seven_segment_scan_shift_driver; predicts every bus event of a scan step
// and checks each one in order, with random gaps, stalls and one long output hold-off
`timescale 1ns / 100ps

module seven_segment_scan_shift_driver_tb;
   import ssd_pkg::*;

   // one serial bus event as seen on the rsp_ channel
   typedef struct packed {
      logic serial_bit;
      logic is_latch;
      logic last_of_step;
   } bus_event_type;

   // per-sample note: typed-in select and segment bytes, where known by hand
   typedef struct packed {
      logic       typed;
      logic [7:0] select;
      logic [7:0] segments;
   } step_note_type;

   typedef enum logic {ROW_SAMPLE, ROW_WRAP} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         typed;
      logic [7:0]   select;
      logic [7:0]   segments;
   } row_type;

   localparam int DIRECTED_ROWS = 27;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_SAMPLES = 24;
   localparam int HOLD_AT_EVENT = 1000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int IDLE_PERCENT  = 19;

   // active-low codes of digits 9 down to 0, digit 0 in the low byte
   localparam logic [79:0] DIGIT_SEGMENTS = {
      8'h90, 8'h80, 8'hf8, 8'h82, 8'h92, 8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0
   };
   localparam logic [7:0] ALL_OFF = 8'hff;

   // directed stimulus: reset state and extremes first, then both wrap extremes
   row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SAMPLE, 8'd0,   1'b1, 8'h01, 8'hc0},
      '{ROW_SAMPLE, 8'd255, 1'b1, 8'h02, 8'hc0},
      '{ROW_SAMPLE, 8'd128, 1'b1, 8'h04, 8'hc0},
      '{ROW_SAMPLE, 8'd99,  1'b1, 8'h08, 8'hc0},
      '{ROW_SAMPLE, 8'd7,   1'b1, 8'h10, 8'hc0},
      '{ROW_SAMPLE, 8'd200, 1'b1, 8'h20, 8'hc0},
      '{ROW_SAMPLE, 8'd1,   1'b1, 8'h40, 8'hc0},
      '{ROW_SAMPLE, 8'd85,  1'b1, 8'h80, 8'hf9},
      '{ROW_SAMPLE, 8'd170, 1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd9,   1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd10,  1'b0, 8'h00, 8'h00},
      '{ROW_WRAP,   8'd7,   1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd15,  1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd240, 1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd60,  1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd100, 1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd254, 1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd101, 1'b0, 8'h00, 8'h00},
      '{ROW_WRAP,   8'd0,   1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd77,  1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd128, 1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd33,  1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd199, 1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd250, 1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd5,   1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd64,  1'b0, 8'h00, 8'h00},
      '{ROW_SAMPLE, 8'd123, 1'b0, 8'h00, 8'h00}
   };

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;   // [7:0] sample_value
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] serial_bit, [7:1] zero
   logic       rsp_tuser;           // [0] is_latch
   logic       rsp_tlast;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_data   = 3'd0;

   // predicted display state
   logic [INDEX_W-1:0] scan_pos = '0;
   logic [INDEX_W-1:0] wrap_sel = WRAP_RESET;
   logic [DIGIT_W-1:0] digit_mem [DIGIT_COUNT];

   bus_event_type pending_events [$];
   step_note_type step_notes [$];

   int  mismatch_count = 0;
   int  events_checked = 0;
   bit  calm           = 1'b0;
   bit  held           = 1'b0;
   int  hold_left      = 0;

   seven_segment_scan_shift_driver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   initial begin
      for (int i = 0; i < DIGIT_COUNT; i++) digit_mem[i] = '0;
   end

   function automatic void push_event(input logic bit_v, input logic latch, input logic last);
      bus_event_type ev;
      ev.serial_bit   = bit_v;
      ev.is_latch     = latch;
      ev.last_of_step = last;
      pending_events.push_back(ev);
   endfunction

   // one scan step: blank, latch, select, segments, latch, then advance and store
   task automatic predict_scan_step(input logic [7:0] sample);
      step_note_type note;
      logic [7:0]    select_byte;
      logic [7:0]    seg_byte;
      logic [3:0]    digit;
      logic [3:0]    next_pos;
      note        = step_notes.pop_front();
      digit       = digit_mem[scan_pos];
      select_byte = 8'h01 << scan_pos;
      seg_byte    = (digit < 4'd10) ? DIGIT_SEGMENTS[digit*8 +: 8] : ALL_OFF;
      if (note.typed) begin
         select_byte = note.select;
         seg_byte    = note.segments;
      end
      for (int i = 0; i < 16; i++) push_event(1'b1, 1'b0, 1'b0);
      push_event(1'b0, 1'b1, 1'b0);
      for (int i = 7; i >= 0; i--) push_event(select_byte[i], 1'b0, 1'b0);
      for (int i = 7; i >= 0; i--) push_event(seg_byte[i], 1'b0, 1'b0);
      push_event(1'b0, 1'b1, 1'b1);
      // index advance with reload from the wrap register
      next_pos = {1'b0, scan_pos} + 4'd1;
      if (next_pos >= DIGIT_COUNT) next_pos = {1'b0, wrap_sel};
      scan_pos = next_pos[INDEX_W-1:0];
      digit_mem[5] = DIGIT_W'(sample / 100);
      digit_mem[6] = DIGIT_W'((sample % 100) / 10);
      digit_mem[7] = DIGIT_W'(sample % 10);
   endtask

   task automatic check_bus_event();
      bus_event_type want;
      if (pending_events.size() == 0) begin
         $display("%0t: unexpected bus event, got data %h latch %b last %b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
         mismatch_count++;
      end else begin
         want = pending_events.pop_front();
         if (rsp_tdata !== {7'd0, want.serial_bit} || rsp_tuser !== want.is_latch ||
             rsp_tlast !== want.last_of_step) begin
            $display("%0t: event %0d expected data %h latch %b last %b, got %h %b %b",
                     $time, events_checked, {7'd0, want.serial_bit}, want.is_latch,
                     want.last_of_step, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end
      end
      events_checked++;
   endtask

   // monitor: every transaction is taken at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) wrap_sel = csr_data;
         if (req_tvalid && req_tready) predict_scan_step(req_tdata);
         if (rsp_tvalid && rsp_tready) check_bus_event();
      end
   end

   // receiver: random stalls, plus one long hold-off so the sample queue fills
   initial begin
      forever begin
         @(negedge clock);
         if (!held && events_checked >= HOLD_AT_EVENT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send_sample(input logic [7:0] sample, input logic typed,
                              input logic [7:0] select, input logic [7:0] segments);
      step_note_type note;
      note.typed    = typed;
      note.select   = select;
      note.segments = segments;
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(255));
         @(negedge clock);
      end
      step_notes.push_back(note);
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // wrap register write, only once every predicted event has come out
   task automatic write_wrap(input logic [2:0] value);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_events.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_sample();
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'(99 + $urandom_range(2));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // stimulus
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_WRAP) begin
            write_wrap(directed_rows[r].value[2:0]);
         end else begin
            send_sample(directed_rows[r].value, directed_rows[r].typed,
                        directed_rows[r].select, directed_rows[r].segments);
         end
      end

      // random phases, one of them with no idling at all
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_wrap(3'($urandom_range(7)));
         calm = (p == 2);
         for (int n = 0; n < PHASE_SAMPLES; n++) send_sample(random_sample(), 1'b0, 8'h00, 8'h00);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
